// File: src/voice_to_midi_event_generator_assert.svh
// Assertion macros for the voice-to-MIDI event generator checker.
`ifndef VOICE_TO_MIDI_EVENT_GENERATOR_ASSERT_SVH
`define VOICE_TO_MIDI_EVENT_GENERATOR_ASSERT_SVH

`define V2M_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

`define V2M_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// File: src/v2m_pkg.sv
// Shared types and constants of the voice-to-MIDI event generator.
package v2m_pkg;

    localparam int NOTE_W     = 8;
    localparam int LEVEL_W    = 16;
    localparam int PITCH_W    = 20;
    localparam int CH_W       = 4;
    localparam int DB_W       = 13;
    localparam int INT_W      = 4;
    localparam int DATA_W     = 7;
    localparam int STAT_W     = 8;
    localparam int BEND_W     = 14;
    localparam int CFG_DATA_W = 13;
    localparam int MSG_MAX    = 3;
    localparam int CNT_W      = 2;
    localparam int QDEPTH     = 2;
    localparam int QPTR_W     = 1;

    localparam logic [STAT_W-1:0] ST_NOTE_OFF = 8'h80;
    localparam logic [STAT_W-1:0] ST_NOTE_ON  = 8'h90;
    localparam logic [STAT_W-1:0] ST_BEND     = 8'hE0;

    localparam logic [BEND_W-1:0] BEND_CENTRE = 14'd8192;
    localparam logic [BEND_W-1:0] BEND_MAX    = 14'd16383;
    localparam logic [DATA_W-1:0] BEND_RST_HI = 7'd64;
    localparam logic [DATA_W-1:0] VEL_MAX     = 7'd127;

    localparam logic [CH_W-1:0]   CH_RST      = 4'd0;
    localparam logic [DB_W-1:0]   DB_RST      = 13'd24;
    localparam logic [INT_W-1:0]  INT_RST     = 4'd2;
    localparam logic [DATA_W-1:0] MINV_RST    = 7'd30;

    typedef enum logic [1:0] {
        CFG_CHANNEL,
        CFG_DEADBAND,
        CFG_INTERVAL,
        CFG_MIN_VEL
    } t_cfg_idx;

    typedef struct packed {
        logic [STAT_W-1:0] status_byte;
        logic [DATA_W-1:0] data_one;
        logic [DATA_W-1:0] data_two;
    } t_msg;

    typedef struct packed {
        logic [CNT_W-1:0]     cnt;
        t_msg [MSG_MAX-1:0]   msg;
    } t_entry;

endpackage

// File: src/v2m_frame_if.sv
// Handshake channel carrying one pitch-tracker frame word.
interface v2m_frame_if import v2m_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic                      link_up;
    logic                      voiced;
    logic                      gate;
    logic signed [NOTE_W-1:0]  note;
    logic signed [LEVEL_W-1:0] level_db;
    logic signed [PITCH_W-1:0] pitch;

    modport source (
        output valid, link_up, voiced, gate, note, level_db, pitch,
        input  ready
    );
    modport sink (
        input  valid, link_up, voiced, gate, note, level_db, pitch,
        output ready
    );
endinterface

// File: src/v2m_msg_if.sv
// Handshake channel carrying one 3-byte MIDI message word.
interface v2m_msg_if import v2m_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status_byte;
    logic [DATA_W-1:0] data_one;
    logic [DATA_W-1:0] data_two;
    logic              last;

    modport source (
        output valid, status_byte, data_one, data_two, last,
        input  ready
    );
    modport sink (
        input  valid, status_byte, data_one, data_two, last,
        output ready
    );
endinterface

// File: src/v2m_queue.sv
// Two-entry queue of per-frame message groups between front and back.
module v2m_queue import v2m_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    output logic   o_full,
    output logic   o_valid,
    output t_entry o_entry,
    input  logic   i_pop
);

    t_entry            r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QPTR_W:0]   r_cnt;

    assign o_full  = (r_cnt == (QPTR_W+1)'(QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_entry = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

endmodule

// File: src/v2m_front.sv
// Front end: config registers, frame classification, note and bend state.
module v2m_front import v2m_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  t_cfg_idx              i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    v2m_frame_if.sink             i_frame,
    input  logic                  i_full,
    output logic                  o_push,
    output t_entry                o_entry
);

    logic [CH_W-1:0]          r_channel;
    logic [DB_W-1:0]          r_deadband;
    logic [INT_W-1:0]         r_interval;
    logic [DATA_W-1:0]        r_min_vel;

    logic signed [NOTE_W-1:0] r_snd;
    logic [BEND_W-1:0]        r_sent;
    logic [INT_W-1:0]         r_cnt;

    logic signed [NOTE_W-1:0] n_snd;
    logic [BEND_W-1:0]        n_sent;
    logic [INT_W-1:0]         n_cnt;

    logic                     accept;
    logic                     voiced_note;
    logic signed [19:0]       vel_num;
    logic [8:0]               vel_raw;
    logic [DATA_W-1:0]        vel;
    logic [INT_W-1:0]         cnt_inc;
    logic                     eval;
    logic signed [21:0]       bend_full;
    logic [BEND_W-1:0]        bend;
    logic signed [BEND_W:0]   diff;
    logic [BEND_W-1:0]        diff_abs;
    logic                     send_bend;
    logic [CNT_W-1:0]         k;
    t_entry                   entry;

    function automatic t_msg make_msg(
        input logic [STAT_W-1:0] st,
        input logic [CH_W-1:0]   ch,
        input logic [DATA_W-1:0] d1,
        input logic [DATA_W-1:0] d2
    );
        t_msg m;
        m.status_byte = st | {{(STAT_W-CH_W){1'b0}}, ch};
        m.data_one    = d1;
        m.data_two    = d2;
        return m;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_channel  <= CH_RST;
            r_deadband <= DB_RST;
            r_interval <= INT_RST;
            r_min_vel  <= MINV_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_CHANNEL:  r_channel  <= i_cfg_data[CH_W-1:0];
                CFG_DEADBAND: r_deadband <= i_cfg_data[DB_W-1:0];
                CFG_INTERVAL: r_interval <= i_cfg_data[INT_W-1:0];
                CFG_MIN_VEL:  r_min_vel  <= i_cfg_data[DATA_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign i_frame.ready = !i_full;
    assign accept        = i_frame.valid && !i_full;
    assign voiced_note   = i_frame.voiced && !i_frame.note[NOTE_W-1];

    // velocity = floor((152*512 + 5*level) / 512), clamped
    assign vel_num = 20'sd77824 + 20'(i_frame.level_db) * 20'sd5;
    assign vel_raw = vel_num[19] ? 9'd0 : vel_num[17:9];

    always_comb begin
        if (vel_raw < {2'b00, r_min_vel}) begin
            vel = r_min_vel;
        end else if (vel_raw > {2'b00, VEL_MAX}) begin
            vel = VEL_MAX;
        end else begin
            vel = vel_raw[DATA_W-1:0];
        end
    end

    assign cnt_inc = r_cnt + 1'b1;
    assign eval    = (cnt_inc >= r_interval);

    assign bend_full = 22'(i_frame.pitch) + 22'($signed({1'b0, BEND_CENTRE}))
                     - (22'(i_frame.note) <<< 12);

    always_comb begin
        if (bend_full[21]) begin
            bend = '0;
        end else if (bend_full[20:BEND_W] != '0) begin
            bend = BEND_MAX;
        end else begin
            bend = bend_full[BEND_W-1:0];
        end
    end

    assign diff      = $signed({1'b0, bend}) - $signed({1'b0, r_sent});
    assign diff_abs  = diff[BEND_W] ? BEND_W'(-diff) : diff[BEND_W-1:0];
    assign send_bend = eval && (diff_abs > {1'b0, r_deadband});

    always_comb begin
        k      = '0;
        entry  = '0;
        n_snd  = r_snd;
        n_sent = r_sent;
        n_cnt  = r_cnt;
        if (!i_frame.link_up) begin
            n_snd = '1;
        end else if (voiced_note) begin
            if (i_frame.note != r_snd) begin
                if (!r_snd[NOTE_W-1]) begin
                    entry.msg[k] = make_msg(ST_NOTE_OFF, r_channel, r_snd[DATA_W-1:0], '0);
                    k = k + 1'b1;
                end
                entry.msg[k] = make_msg(ST_NOTE_ON, r_channel,
                                        i_frame.note[DATA_W-1:0], vel);
                k = k + 1'b1;
                n_snd = i_frame.note;
            end
            n_cnt = eval ? '0 : cnt_inc;
            if (send_bend) begin
                entry.msg[k] = make_msg(ST_BEND, r_channel, bend[DATA_W-1:0],
                                        bend[BEND_W-1:DATA_W]);
                k = k + 1'b1;
                n_sent = bend;
            end
        end else if (!i_frame.gate) begin
            if (!r_snd[NOTE_W-1]) begin
                entry.msg[k] = make_msg(ST_NOTE_OFF, r_channel, r_snd[DATA_W-1:0], '0);
                k = k + 1'b1;
                n_snd = '1;
            end
            if (r_sent != BEND_CENTRE) begin
                entry.msg[k] = make_msg(ST_BEND, r_channel, '0, BEND_RST_HI);
                k = k + 1'b1;
                n_sent = BEND_CENTRE;
            end
        end
        entry.cnt = k;
    end

    assign o_push  = accept && (k != '0);
    assign o_entry = entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_snd  <= '1;
            r_sent <= BEND_CENTRE;
            r_cnt  <= '0;
        end else if (accept) begin
            r_snd  <= n_snd;
            r_sent <= n_sent;
            r_cnt  <= n_cnt;
        end
    end

endmodule

// File: src/v2m_back.sv
// Back end: serializes one queued message group onto the output channel.
module v2m_back import v2m_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  t_entry     i_entry,
    output logic       o_pop,
    v2m_msg_if.source  o_msg
);

    logic             r_busy;
    t_entry           r_ent;
    logic [CNT_W-1:0] r_idx;

    logic             is_last;
    logic             fire;

    assign is_last = (r_idx == (r_ent.cnt - 1'b1));
    assign fire    = r_busy && o_msg.ready;
    assign o_pop   = i_valid && (!r_busy || (fire && is_last));

    assign o_msg.valid       = r_busy;
    assign o_msg.status_byte = r_ent.msg[r_idx].status_byte;
    assign o_msg.data_one    = r_ent.msg[r_idx].data_one;
    assign o_msg.data_two    = r_ent.msg[r_idx].data_two;
    assign o_msg.last        = is_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (o_pop) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (fire && is_last) begin
            r_busy <= 1'b0;
        end else if (fire) begin
            r_idx <= r_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_ent <= i_entry;
        end
    end

endmodule

// File: src/voice_to_midi_event_generator.sv
// Voice-to-MIDI event generator top level: front end, message queue, back end.
// A frame's first message word is offered after the queue and then the back end register it.
// Throughput: one frame word per cycle into the front while the queue is not full;
// one message word per cycle out while the output is ready (two-entry queue).
// Reset (synchronous, active low) restores register defaults, clears note/bend state
// and empties the queue.
module voice_to_midi_event_generator import v2m_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  t_cfg_idx              i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    v2m_frame_if.sink             i_frame,
    v2m_msg_if.source             o_msg
);

    logic   push;
    logic   full;
    logic   q_valid;
    logic   pop;
    t_entry push_entry;
    t_entry q_entry;

    v2m_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_frame    (i_frame),
        .i_full     (full),
        .o_push     (push),
        .o_entry    (push_entry)
    );

    v2m_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .o_full  (full),
        .o_valid (q_valid),
        .o_entry (q_entry),
        .i_pop   (pop)
    );

    v2m_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_entry (q_entry),
        .o_pop   (pop),
        .o_msg   (o_msg)
    );

endmodule

// File: src/v2m_checker.sv
// Port-level checker for the voice-to-MIDI event generator, with its bind.
`include "voice_to_midi_event_generator_assert.svh"

module v2m_checker import v2m_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_valid,
    input logic              i_ready,
    input logic [STAT_W-1:0] i_status,
    input logic [DATA_W-1:0] i_data_one,
    input logic [DATA_W-1:0] i_data_two,
    input logic              i_last
);

    `V2M_ASSERT_RST(a_rst_idle, (!i_rst_n |=> !i_valid), "output word valid after reset")

    `V2M_ASSERT(a_status_kind, (i_valid |-> (i_status[7:4] == ST_NOTE_OFF[7:4] || i_status[7:4] == ST_NOTE_ON[7:4] || i_status[7:4] == ST_BEND[7:4])), "unknown status kind")

    `V2M_ASSERT(a_off_zero_vel, (i_valid && i_status[7:4] == ST_NOTE_OFF[7:4] |-> i_data_two == '0), "note-off with nonzero velocity")

    `V2M_ASSERT(a_stall_hold, (i_valid && !i_ready |=> i_valid && $stable(i_status) && $stable(i_data_one) && $stable(i_data_two) && $stable(i_last)), "stalled word changed")

endmodule

bind voice_to_midi_event_generator v2m_checker u_v2m_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_valid    (o_msg.valid),
    .i_ready    (o_msg.ready),
    .i_status   (o_msg.status_byte),
    .i_data_one (o_msg.data_one),
    .i_data_two (o_msg.data_two),
    .i_last     (o_msg.last)
);

// File: tb/tb_top.sv
// Self-checking testbench of the voice-to-MIDI event generator: frames in, MIDI words checked.
module tb_top;
    import v2m_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SEMI_Q     = 4096;
    localparam int VEL_BIAS   = 152 * 512;
    localparam int PITCH_MAX  = 524287;
    localparam int PITCH_MIN  = -524288;
    localparam int STALL_PCT  = 23;
    localparam int DRAIN_MAX  = 5000;
    localparam int SETTLE_CYC = 12;

    typedef struct packed {
        logic                      link_up;
        logic                      voiced;
        logic                      gate;
        logic signed [NOTE_W-1:0]  note;
        logic signed [LEVEL_W-1:0] level_db;
        logic signed [PITCH_W-1:0] pitch;
    } t_frame;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [DATA_W-1:0] d1;
        logic [DATA_W-1:0] d2;
        logic              last;
    } t_midi_word;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    t_cfg_idx              cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    v2m_frame_if u_frame ();
    v2m_msg_if   u_msg ();

    voice_to_midi_event_generator u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_frame    (u_frame),
        .o_msg      (u_msg)
    );

    t_frame     frame_backlog[$];
    t_midi_word midi_expected[$];

    logic [CH_W-1:0]  cfg_channel;
    int               cfg_deadband;
    logic [INT_W-1:0] cfg_interval;
    int               cfg_min_vel;

    int               cur_note;
    int               cur_bend;
    logic [INT_W-1:0] bend_tick;

    int frames_sent;
    int frames_taken;
    int words_checked;
    int mismatches;
    int stall_pct;
    int settings_run;
    int live_frames;

    always #2 i_clk = ~i_clk;

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("mismatch: %s", msg);
    endtask

    function automatic t_midi_word mk_word(input logic [STAT_W-1:0] st, input int d1,
                                           input int d2);
        t_midi_word w;
        w.status = st | {{(STAT_W-CH_W){1'b0}}, cfg_channel};
        w.d1     = d1[DATA_W-1:0];
        w.d2     = d2[DATA_W-1:0];
        w.last   = 1'b0;
        return w;
    endfunction

    task automatic predict_midi(input t_frame f);
        t_midi_word words[MSG_MAX];
        int k;
        int i;
        int nt;
        int vel;
        int bend;
        int diff;
        k  = 0;
        nt = $signed(f.note);
        if (!f.link_up) begin
            cur_note = -1;
            return;
        end
        if (f.voiced && nt >= 0) begin
            if (nt != cur_note) begin
                vel = VEL_BIAS + 5 * $signed(f.level_db);
                vel = (vel < 0) ? 0 : (vel >> 9);
                if (vel < cfg_min_vel) vel = cfg_min_vel;
                if (vel > int'(VEL_MAX)) vel = int'(VEL_MAX);
                if (cur_note >= 0) begin
                    words[k] = mk_word(ST_NOTE_OFF, cur_note, 0);
                    k++;
                end
                words[k] = mk_word(ST_NOTE_ON, nt, vel);
                k++;
                cur_note = nt;
            end
            bend_tick = bend_tick + 1'b1;
            if (bend_tick >= cfg_interval) begin
                bend_tick = '0;
                bend = int'(BEND_CENTRE) + $signed(f.pitch) - SEMI_Q * nt;
                if (bend < 0) bend = 0;
                if (bend > int'(BEND_MAX)) bend = int'(BEND_MAX);
                diff = bend - cur_bend;
                if (diff < 0) diff = -diff;
                if (diff > cfg_deadband) begin
                    words[k] = mk_word(ST_BEND, bend & 'h7F, bend >> 7);
                    k++;
                    cur_bend = bend;
                end
            end
        end else if (!f.gate) begin
            if (cur_note >= 0) begin
                words[k] = mk_word(ST_NOTE_OFF, cur_note, 0);
                k++;
                cur_note = -1;
            end
            if (cur_bend != int'(BEND_CENTRE)) begin
                words[k] = mk_word(ST_BEND, 0, int'(BEND_RST_HI));
                k++;
                cur_bend = int'(BEND_CENTRE);
            end
        end
        if (k > 0) words[k-1].last = 1'b1;
        for (i = 0; i < k; i++) midi_expected.push_back(words[i]);
    endtask

    // Frame driver: take the handshake at the rising edge, drive at the falling edge.
    always @(posedge i_clk) begin : frame_take
        t_frame f;
        if (i_rst_n && u_frame.valid && u_frame.ready) begin
            f.link_up  = u_frame.link_up;
            f.voiced   = u_frame.voiced;
            f.gate     = u_frame.gate;
            f.note     = u_frame.note;
            f.level_db = u_frame.level_db;
            f.pitch    = u_frame.pitch;
            predict_midi(f);
            frames_taken <= frames_taken + 1;
        end
    end

    always @(negedge i_clk) begin : frame_drive
        t_frame f;
        if (i_rst_n && frames_sent == frames_taken) begin
            if (frame_backlog.size() != 0 && $urandom_range(99) >= stall_pct) begin
                f = frame_backlog.pop_front();
                u_frame.link_up  <= f.link_up;
                u_frame.voiced   <= f.voiced;
                u_frame.gate     <= f.gate;
                u_frame.note     <= f.note;
                u_frame.level_db <= f.level_db;
                u_frame.pitch    <= f.pitch;
                u_frame.valid    <= 1'b1;
                frames_sent      <= frames_sent + 1;
            end else begin
                u_frame.valid <= 1'b0;
            end
        end
    end

    // MIDI word monitor.
    always @(negedge i_clk) begin
        u_msg.ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin : midi_check
        t_midi_word w;
        if (i_rst_n && u_msg.valid && u_msg.ready) begin
            if (midi_expected.size() == 0) begin
                report_mismatch($sformatf("unexpected word %02h %02h %02h last=%0b",
                    u_msg.status_byte, u_msg.data_one, u_msg.data_two, u_msg.last));
            end else begin
                w = midi_expected.pop_front();
                words_checked++;
                if (u_msg.status_byte !== w.status)
                    report_mismatch($sformatf("word %0d status %02h, want %02h",
                        words_checked, u_msg.status_byte, w.status));
                if (u_msg.data_one !== w.d1)
                    report_mismatch($sformatf("word %0d data_one %0d, want %0d",
                        words_checked, u_msg.data_one, w.d1));
                if (u_msg.data_two !== w.d2)
                    report_mismatch($sformatf("word %0d data_two %0d, want %0d",
                        words_checked, u_msg.data_two, w.d2));
                if (u_msg.last !== w.last)
                    report_mismatch($sformatf("word %0d last %0b, want %0b",
                        words_checked, u_msg.last, w.last));
            end
        end
    end

    task automatic write_reg(input t_cfg_idx idx, input int value);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value[CFG_DATA_W-1:0];
        case (idx)
            CFG_CHANNEL:  cfg_channel  = value[CH_W-1:0];
            CFG_DEADBAND: cfg_deadband = value[DB_W-1:0];
            CFG_INTERVAL: cfg_interval = value[INT_W-1:0];
            CFG_MIN_VEL:  cfg_min_vel  = value[DATA_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_regs(input int ch, input int db, input int intv, input int minv);
        write_reg(CFG_CHANNEL, ch);
        write_reg(CFG_DEADBAND, db);
        write_reg(CFG_INTERVAL, intv);
        write_reg(CFG_MIN_VEL, minv);
        settings_run++;
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        while ((frame_backlog.size() != 0 || frames_sent != frames_taken ||
                midi_expected.size() != 0) && guard < DRAIN_MAX) begin
            @(posedge i_clk);
            guard++;
        end
        if (frame_backlog.size() != 0 || frames_sent != frames_taken) begin
            report_mismatch($sformatf("%0d frame words never taken",
                frame_backlog.size() + frames_sent - frames_taken));
            frame_backlog.delete();
        end
        if (midi_expected.size() != 0) begin
            report_mismatch($sformatf("%0d expected words never arrived",
                midi_expected.size()));
            midi_expected.delete();
        end
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    function automatic t_frame mk_frame(input int link, input int voi, input int gt,
                                        input int nt, input int lvl, input int pt);
        t_frame f;
        f.link_up  = link[0];
        f.voiced   = voi[0];
        f.gate     = gt[0];
        f.note     = nt[NOTE_W-1:0];
        f.level_db = lvl[LEVEL_W-1:0];
        f.pitch    = pt[PITCH_W-1:0];
        return f;
    endfunction

    function automatic int rand_level();
        if ($urandom_range(99) < 15) return $signed(16'($urandom()));
        return int'($urandom_range(0, 22000)) - 20000;
    endfunction

    function automatic int near_pitch(input int nt);
        int p;
        if ($urandom_range(9) == 0) return $signed(20'($urandom()));
        p = nt * SEMI_Q + int'($urandom_range(0, 20000)) - 10000;
        if (p > PITCH_MAX) p = PITCH_MAX;
        if (p < PITCH_MIN) p = PITCH_MIN;
        return p;
    endfunction

    task automatic queue_frame(input t_frame f);
        frame_backlog.push_back(f);
        if (f.link_up) live_frames++;
    endtask

    // Mostly held notes with random pitch and level, mixed with noise and broken sequences.
    task automatic queue_random(input int count);
        int goal;
        int base;
        int len;
        int i;
        int pick;
        goal = live_frames + count;
        while (live_frames < goal) begin
            pick = $urandom_range(99);
            if (pick < 60) begin
                base = $urandom_range(0, 127);
                len  = $urandom_range(1, 8);
                for (i = 0; i < len; i++) begin
                    if ($urandom_range(9) == 0) base = $urandom_range(0, 127);
                    queue_frame(mk_frame(1, 1, $urandom_range(0, 1), base, rand_level(),
                        near_pitch(base)));
                end
                if ($urandom_range(1))
                    queue_frame(mk_frame(1, 0, $urandom_range(3) == 0, base, rand_level(),
                        near_pitch(base)));
                else
                    queue_frame(mk_frame(1, 1, $urandom_range(3) == 0, -1, rand_level(),
                        near_pitch(base)));
            end else if (pick < 70) begin
                queue_frame(mk_frame(0, $urandom_range(0, 1), $urandom_range(0, 1),
                    int'($urandom_range(0, 128)) - 1, rand_level(), $signed(20'($urandom()))));
            end else if (pick < 80) begin
                queue_frame(mk_frame(1, 1, $urandom_range(0, 1), -1, rand_level(),
                    $signed(20'($urandom()))));
            end else begin
                queue_frame(mk_frame(1, $urandom_range(0, 1), $urandom_range(0, 1),
                    int'($urandom_range(0, 128)) - 1, $signed(16'($urandom())),
                    $signed(20'($urandom()))));
            end
        end
    endtask

    initial begin
        #400000;
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        i_clk            = 1'b0;
        i_rst_n          = 1'b0;
        cfg_we           = 1'b0;
        cfg_idx          = CFG_CHANNEL;
        cfg_data         = '0;
        u_frame.valid    = 1'b0;
        u_frame.link_up  = 1'b0;
        u_frame.voiced   = 1'b0;
        u_frame.gate     = 1'b0;
        u_frame.note     = '0;
        u_frame.level_db = '0;
        u_frame.pitch    = '0;
        u_msg.ready      = 1'b0;
        cfg_channel      = CH_RST;
        cfg_deadband     = int'(DB_RST);
        cfg_interval     = INT_RST;
        cfg_min_vel      = int'(MINV_RST);
        cur_note         = -1;
        cur_bend         = int'(BEND_CENTRE);
        bend_tick        = '0;
        frames_sent      = 0;
        frames_taken     = 0;
        words_checked    = 0;
        mismatches       = 0;
        stall_pct        = STALL_PCT;
        settings_run     = 1;
        live_frames      = 0;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset defaults: note changes, same-note bends, saturation, silencing, link loss.
        queue_frame(mk_frame(0, 1, 1, 60, 0, 60 * SEMI_Q));
        queue_frame(mk_frame(1, 1, 1, 60, 0, 60 * SEMI_Q));
        queue_frame(mk_frame(1, 1, 1, 60, 0, 60 * SEMI_Q + 4000));
        queue_frame(mk_frame(1, 1, 0, 61, -32768, 61 * SEMI_Q));
        queue_frame(mk_frame(1, 1, 0, 61, -32768, 61 * SEMI_Q));
        queue_frame(mk_frame(1, 1, 1, 127, 32767, PITCH_MAX));
        queue_frame(mk_frame(1, 1, 1, 127, 32767, PITCH_MAX));
        queue_frame(mk_frame(1, 1, 1, 0, -10240, PITCH_MIN));
        queue_frame(mk_frame(1, 1, 1, 0, -10240, PITCH_MIN));
        queue_frame(mk_frame(1, 1, 1, 0, -15360, PITCH_MAX));
        queue_frame(mk_frame(1, 1, 1, 0, -15360, PITCH_MAX));
        queue_frame(mk_frame(1, 0, 1, 0, 0, 0));
        queue_frame(mk_frame(1, 1, 1, -1, 0, 0));
        queue_frame(mk_frame(1, 1, 0, -1, 0, 0));
        queue_frame(mk_frame(1, 0, 0, 0, 0, 0));
        queue_frame(mk_frame(1, 1, 1, 64, -10240, 64 * SEMI_Q + 10));
        queue_frame(mk_frame(0, 1, 1, 64, -10240, 64 * SEMI_Q));
        queue_frame(mk_frame(1, 1, 1, 64, -10240, 64 * SEMI_Q + 30));
        queue_frame(mk_frame(1, 1, 1, 64, -10240, 64 * SEMI_Q + 20));
        queue_frame(mk_frame(1, 1, 1, 64, -12000, 64 * SEMI_Q + 3000));
        queue_frame(mk_frame(1, 0, 0, 64, 0, 0));
        queue_frame(mk_frame(1, 0, 0, 64, 0, 0));
        drain();

        // Low extremes: every voiced frame evaluates a bend, no deadband, no velocity floor.
        set_regs(15, 0, 0, 0);
        queue_frame(mk_frame(1, 1, 1, 5, -32768, 5 * SEMI_Q + 1));
        queue_frame(mk_frame(1, 1, 1, 5, -32768, 5 * SEMI_Q + 2));
        queue_frame(mk_frame(1, 0, 0, 5, 0, 0));
        queue_random(30);
        drain();

        // High extremes.
        set_regs($urandom_range(0, 15), 8191, 15, 127);
        queue_random(25);
        drain();

        // Long stretch without idling on either side.
        stall_pct = 0;
        set_regs(5, 24, 1, 1);
        queue_random(35);
        drain();
        stall_pct = STALL_PCT;

        set_regs($urandom_range(0, 15), $urandom_range(0, 200), $urandom_range(1, 4),
            $urandom_range(1, 127));
        queue_random(35);
        drain();

        $display("covered %0d frames (%0d with link up) over %0d register settings",
            frames_taken, live_frames, settings_run);
        $display("checked %0d MIDI words, %0d mismatches", words_checked, mismatches);
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+src
src/v2m_pkg.sv
src/v2m_frame_if.sv
src/v2m_msg_if.sv
src/v2m_queue.sv
src/v2m_front.sv
src/v2m_back.sv
src/voice_to_midi_event_generator.sv
src/v2m_checker.sv
tb/tb_top.sv
